// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the filter RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, disabled while reset is asserted (active low).
`define WGCA_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked property checked also during reset.
`define WGCA_ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ----- hdl/wgca_pkg.sv -----
// Package of the window gap cluster average filter.
// Field widths, sequencer states and the cell control struct; no dependencies.
`default_nettype none

package wgca_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int MEAN_W     = 24;
  localparam int COUNT_W    = 4;
  localparam int FRAC_W     = 8;
  localparam int WINDOW_DEF = 8;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SORT,
    ST_SCAN,
    ST_PREP,
    ST_DIV,
    ST_OUT
  } state_e;

  typedef struct packed {
    logic load;
    logic sort;
    logic shift;
    logic odd;
  } cell_ctrl_t;

endpackage

`default_nettype wire

// ----- hdl/window_gap_cluster_average_filter.sv -----
// Top level of the window gap cluster average filter: sample window, row of
// sorting cells, gap scan, cluster select and divider.
// Depends on wgca_pkg, wgca_cell, wgca_div and assert_macros.svh.
//
// Usage:
//  Input channel in_valid_i / in_stall_o carries sample_mm_i; an item is taken
//  on a clock edge with in_valid_i high and in_stall_o low. Output channel
//  out_valid_o / out_stall_i carries filtered_mm_q8_o and cluster_count_o.
//  One item is processed at a time. From acceptance the result passes through
//  WINDOW sort phases in the cell row, WINDOW-1 scan steps, a select step,
//  a one-bit-per-cycle divider of 24 + clog2(WINDOW) steps and the output
//  load, in that order. The divider dominates, then the sort phases of
//  the cell row. The next item is taken as soon as its result is in the
//  output register, even if that result is still stalled; a new result
//  waits in the divider until the output register is free.
//  Reset empties the pipeline and sets all window entries to zero, which
//  then take part as ordinary samples. No clearing pass is needed.
`default_nettype none

`include "assert_macros.svh"

module window_gap_cluster_average_filter #(
  parameter int WINDOW = wgca_pkg::WINDOW_DEF
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          in_valid_i,
  output logic                               in_stall_o,
  input  wire logic [wgca_pkg::SAMPLE_W-1:0] sample_mm_i,
  output logic                               out_valid_o,
  input  wire logic                          out_stall_i,
  output logic      [wgca_pkg::MEAN_W-1:0]   filtered_mm_q8_o,
  output logic      [wgca_pkg::COUNT_W-1:0]  cluster_count_o
);

  localparam int SW    = wgca_pkg::SAMPLE_W;
  localparam int CW    = wgca_pkg::COUNT_W;
  localparam int CNT_W = $clog2(WINDOW);
  localparam int SUM_W = SW + $clog2(WINDOW);
  localparam int DVD_W = SUM_W + wgca_pkg::FRAC_W;
  localparam int HALF  = (WINDOW + 1) / 2;

  wgca_pkg::state_e     state_q, state_d;
  wgca_pkg::cell_ctrl_t cell_ctrl;

  logic [SW-1:0]    win_q [WINDOW];
  logic [SW-1:0]    win_d [WINDOW];
  logic [SW-1:0]    cell_v [WINDOW];
  logic [CNT_W-1:0] cnt_q;
  logic             accept, cnt_clr, cnt_inc, scan_en, div_start, out_load;
  logic             cnt_sort_end, cnt_scan_end;

  logic [SW-1:0]    best_q, gap;
  logic [CNT_W-1:0] idx_q;
  logic [SUM_W-1:0] pref_q, bpref_q, total_q, pref_new;
  logic             better;

  logic             lower;
  logic [SUM_W-1:0] sel_sum;
  logic [CW-1:0]    sel_cnt, clus_q;
  logic             div_done;
  logic [DVD_W-1:0] quotient;
  logic             out_valid_q;

  assign accept       = in_valid_i && !in_stall_o;
  assign cnt_sort_end = cnt_q == CNT_W'(WINDOW - 1);
  assign cnt_scan_end = cnt_q == CNT_W'(WINDOW - 2);

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      wgca_pkg::ST_IDLE: if (in_valid_i) state_d = wgca_pkg::ST_SORT;
      wgca_pkg::ST_SORT: if (cnt_sort_end) state_d = wgca_pkg::ST_SCAN;
      wgca_pkg::ST_SCAN: if (cnt_scan_end) state_d = wgca_pkg::ST_PREP;
      wgca_pkg::ST_PREP: state_d = wgca_pkg::ST_DIV;
      wgca_pkg::ST_DIV:  if (div_done) state_d = wgca_pkg::ST_OUT;
      wgca_pkg::ST_OUT:  if (!out_valid_q || !out_stall_i) state_d = wgca_pkg::ST_IDLE;
      default:           state_d = wgca_pkg::ST_IDLE;
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    in_stall_o = 1'b1;
    cell_ctrl  = '0;
    cnt_clr    = 1'b0;
    cnt_inc    = 1'b0;
    scan_en    = 1'b0;
    div_start  = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      wgca_pkg::ST_IDLE: begin
        in_stall_o     = 1'b0;
        cell_ctrl.load = in_valid_i;
        cnt_clr        = 1'b1;
      end
      wgca_pkg::ST_SORT: begin
        cell_ctrl.sort = 1'b1;
        cell_ctrl.odd  = cnt_q[0];
        cnt_clr        = cnt_sort_end;
        cnt_inc        = !cnt_sort_end;
      end
      wgca_pkg::ST_SCAN: begin
        cell_ctrl.shift = 1'b1;
        scan_en         = 1'b1;
        cnt_inc         = 1'b1;
      end
      wgca_pkg::ST_PREP: div_start = 1'b1;
      wgca_pkg::ST_DIV:  ;
      wgca_pkg::ST_OUT:  out_load = !out_valid_q || !out_stall_i;
      default:           ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= wgca_pkg::ST_IDLE;
      cnt_q   <= '0;
    end else begin
      state_q <= state_d;
      if (cnt_clr) begin
        cnt_q <= '0;
      end else if (cnt_inc) begin
        cnt_q <= cnt_q + 1'b1;
      end
    end
  end

  // sample window, index 0 oldest
  always_comb begin
    for (int k = 0; k < WINDOW - 1; k++) begin
      win_d[k] = win_q[k + 1];
    end
    win_d[WINDOW - 1] = sample_mm_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < WINDOW; k++) begin
        win_q[k] <= '0;
      end
    end else if (accept) begin
      win_q <= win_d;
    end
  end

  // sorting row
  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    logic [SW-1:0] left_v, right_v;
    if (i == 0) begin : g_first
      assign left_v = '0;
    end else begin : g_mid_l
      assign left_v = cell_v[i - 1];
    end
    if (i == WINDOW - 1) begin : g_last
      assign right_v = '0;
    end else begin : g_mid_r
      assign right_v = cell_v[i + 1];
    end
    wgca_cell #(
      .WINDOW (WINDOW),
      .IDX    (i)
    ) u_cell (
      .clk_i      (clk_i),
      .ctrl_i     (cell_ctrl),
      .load_val_i (win_d[i]),
      .left_i     (left_v),
      .right_i    (right_v),
      .val_o      (cell_v[i])
    );
  end

  // gap scan over the sorted row as it shifts past cells 0 and 1
  always_comb begin
    gap      = cell_v[1] - cell_v[0];
    pref_new = pref_q + SUM_W'(cell_v[0]);
    better   = (cnt_q == '0) || (gap > best_q);
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      pref_q <= '0;
    end else if (scan_en) begin
      pref_q <= pref_new;
      if (better) begin
        best_q  <= gap;
        idx_q   <= cnt_q;
        bpref_q <= pref_new;
      end
      if (cnt_scan_end) begin
        total_q <= pref_new + SUM_W'(cell_v[1]);
      end
    end
  end

  // cluster select
  always_comb begin
    lower   = ((CW + 1)'(idx_q) + 1'b1) > (CW + 1)'(HALF);
    sel_sum = lower ? bpref_q : total_q - bpref_q;
    sel_cnt = lower ? CW'(idx_q) + 1'b1 : CW'(WINDOW - 1) - CW'(idx_q);
  end

  always_ff @(posedge clk_i) begin
    if (div_start) begin
      clus_q <= sel_cnt;
    end
  end

  wgca_div #(
    .DVD_W (DVD_W)
  ) u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({sel_sum, {wgca_pkg::FRAC_W{1'b0}}}),
    .divisor_i  (sel_cnt),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      filtered_mm_q8_o <= quotient[wgca_pkg::MEAN_W-1:0];
      cluster_count_o  <= clus_q;
    end
  end

  assign out_valid_o = out_valid_q;

  `WGCA_ASSERT(a_accept_sorts, clk_i, rst_ni, accept |=> (state_q == wgca_pkg::ST_SORT), "item accepted but sort not started")
  `WGCA_ASSERT(a_scan_sorted, clk_i, rst_ni, (state_q == wgca_pkg::ST_SCAN) |-> (cell_v[0] <= cell_v[1]), "cell row not sorted during scan")
  `WGCA_ASSERT(a_div_done_state, clk_i, rst_ni, div_done |-> (state_q == wgca_pkg::ST_DIV), "divider finished outside its state")
  `WGCA_ASSERT(a_out_from_seq, clk_i, rst_ni, $rose(out_valid_o) |-> ($past(state_q) == wgca_pkg::ST_OUT), "result shown without output load")
  `WGCA_ASSERT(a_count_range, clk_i, rst_ni, out_valid_o |-> ((cluster_count_o != '0) && (cluster_count_o <= CW'(WINDOW - 1))), "cluster count out of range")

endmodule

`default_nettype wire

// ----- hdl/wgca_cell.sv -----
// One cell of the sorting row: holds a sample, compare-swaps with a neighbour
// in alternating phases and shifts towards cell 0 during the gap scan.
// Depends on wgca_pkg.
`default_nettype none

module wgca_cell #(
  parameter int WINDOW = wgca_pkg::WINDOW_DEF,
  parameter int IDX    = 0
) (
  input  wire logic                         clk_i,
  input  wire wgca_pkg::cell_ctrl_t         ctrl_i,
  input  wire logic [wgca_pkg::SAMPLE_W-1:0] load_val_i,
  input  wire logic [wgca_pkg::SAMPLE_W-1:0] left_i,
  input  wire logic [wgca_pkg::SAMPLE_W-1:0] right_i,
  output logic      [wgca_pkg::SAMPLE_W-1:0] val_o
);

  localparam bit IS_ODD    = (IDX % 2) == 1;
  localparam bit HAS_LEFT  = IDX > 0;
  localparam bit HAS_RIGHT = IDX < WINDOW - 1;

  logic [wgca_pkg::SAMPLE_W-1:0] val_q, val_d;
  logic                          is_lower, is_upper;

  always_comb begin
    is_lower = (ctrl_i.odd == IS_ODD) && HAS_RIGHT;
    is_upper = (ctrl_i.odd != IS_ODD) && HAS_LEFT;
    val_d    = val_q;
    if (ctrl_i.load) begin
      val_d = load_val_i;
    end else if (ctrl_i.sort) begin
      if (is_lower && (right_i < val_q)) begin
        val_d = right_i;
      end else if (is_upper && (left_i > val_q)) begin
        val_d = left_i;
      end
    end else if (ctrl_i.shift) begin
      val_d = right_i;
    end
  end

  always_ff @(posedge clk_i) begin
    val_q <= val_d;
  end

  assign val_o = val_q;

endmodule

`default_nettype wire

// ----- hdl/wgca_div.sv -----
// Restoring divider, one quotient bit per cycle, for the cluster mean.
// Depends on wgca_pkg.
`default_nettype none

module wgca_div #(
  parameter int DVD_W = wgca_pkg::SAMPLE_W + $clog2(wgca_pkg::WINDOW_DEF) + wgca_pkg::FRAC_W
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [DVD_W-1:0]            dividend_i,
  input  wire logic [wgca_pkg::COUNT_W-1:0] divisor_i,
  output logic                             done_o,
  output logic      [DVD_W-1:0]            quotient_o
);

  localparam int DV_W   = wgca_pkg::COUNT_W;
  localparam int STEP_W = $clog2(DVD_W);

  logic              busy_q;
  logic [STEP_W-1:0] step_q;
  logic [DV_W-1:0]   dvs_q, rem_q, rem_d;
  logic [DVD_W-1:0]  quo_q;
  logic [DV_W:0]     trial;
  logic              ge;

  always_comb begin
    trial = {rem_q, quo_q[DVD_W-1]};
    ge    = trial >= {1'b0, dvs_q};
    rem_d = ge ? DV_W'(trial - {1'b0, dvs_q}) : trial[DV_W-1:0];
  end

  assign done_o     = busy_q && (step_q == STEP_W'(DVD_W - 1));
  assign quotient_o = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= '0;
    end else if (start_i) begin
      busy_q <= 1'b1;
      step_q <= '0;
    end else if (busy_q) begin
      busy_q <= !done_o;
      step_q <= step_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= '0;
      quo_q <= dividend_i;
      dvs_q <= divisor_i;
    end else if (busy_q) begin
      rem_q <= rem_d;
      quo_q <= {quo_q[DVD_W-2:0], ge};
    end
  end

endmodule

`default_nettype wire

// ----- sim/window_gap_cluster_average_filter_test.sv -----
// Self-checking testbench of window_gap_cluster_average_filter: random and directed
// range samples, with predicted cluster means checked against every result item.
// Depends on wgca_pkg and the filter RTL only.
module window_gap_cluster_average_filter_test;

  localparam int WINDOW      = wgca_pkg::WINDOW_DEF;
  localparam int SAMPLE_W    = wgca_pkg::SAMPLE_W;
  localparam int MEAN_W      = wgca_pkg::MEAN_W;
  localparam int COUNT_W     = wgca_pkg::COUNT_W;
  localparam int FRAC_W      = wgca_pkg::FRAC_W;
  localparam int RANDOM_N    = 1427;
  localparam int HOLD_AT     = 500;
  localparam int HOLD_CYCLES = 400;
  localparam int TAIL_CYCLES = 120;
  localparam int LIMIT       = 1000000;

  typedef enum int {STEADY, UNIFORM, TWO_TARGET, FROZEN} plan_mode_e;

  typedef struct {
    logic [SAMPLE_W-1:0] sample_mm;
    int                  idle_before;
    bit                  drain_first;
  } plan_item_t;

  typedef struct {
    logic [MEAN_W-1:0]  mean_q8;
    logic [COUNT_W-1:0] count;
  } cluster_mean_t;

  logic                clk_i       = 1'b0;
  logic                rst_ni      = 1'b0;
  logic                in_valid_i  = 1'b0;
  logic [SAMPLE_W-1:0] sample_mm_i = '0;
  logic                out_stall_i = 1'b0;
  logic                in_stall_o;
  logic                out_valid_o;
  logic [MEAN_W-1:0]   filtered_mm_q8_o;
  logic [COUNT_W-1:0]  cluster_count_o;

  plan_item_t          sample_plan[$];
  cluster_mean_t       means_due[$];
  logic [SAMPLE_W-1:0] window_mm [WINDOW];
  int                  idle_cycles;
  int                  items_sent;
  int                  results_seen;
  int                  stall_left;
  int                  hold_left;
  int                  fails = 0;
  int                  cycles = 0;

  window_gap_cluster_average_filter #(.WINDOW(WINDOW)) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_stall_o      (in_stall_o),
    .sample_mm_i     (sample_mm_i),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .filtered_mm_q8_o(filtered_mm_q8_o),
    .cluster_count_o (cluster_count_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Shift a sample into the window and queue the mean of the cluster it selects.
  task automatic shift_in_and_average(input logic [SAMPLE_W-1:0] sample);
    logic [SAMPLE_W-1:0] sorted_mm [WINDOW];
    logic [SAMPLE_W-1:0] swap;
    logic [SAMPLE_W:0]   best_gap;
    logic [SAMPLE_W:0]   gap;
    logic [31:0]         total;
    logic [31:0]         members;
    int                  gap_at;
    int                  lo;
    int                  hi;
    cluster_mean_t       res;
    for (int k = 0; k < WINDOW - 1; k++) window_mm[k] = window_mm[k + 1];
    window_mm[WINDOW - 1] = sample;
    sorted_mm = window_mm;
    for (int p = 0; p < WINDOW - 1; p++)
      for (int k = 0; k + 1 + p < WINDOW; k++)
        if (sorted_mm[k] > sorted_mm[k + 1]) begin
          swap             = sorted_mm[k];
          sorted_mm[k]     = sorted_mm[k + 1];
          sorted_mm[k + 1] = swap;
        end
    gap_at   = 0;
    best_gap = {1'b0, sorted_mm[1]} - {1'b0, sorted_mm[0]};
    for (int k = 1; k + 1 < WINDOW; k++) begin
      gap = {1'b0, sorted_mm[k + 1]} - {1'b0, sorted_mm[k]};
      if (gap > best_gap) begin
        best_gap = gap;
        gap_at   = k;
      end
    end
    if (gap_at + 1 > (WINDOW + 1) / 2) begin
      lo = 0;
      hi = gap_at;
    end else begin
      lo = gap_at + 1;
      hi = WINDOW - 1;
    end
    total = '0;
    for (int k = lo; k <= hi; k++) total += 32'(sorted_mm[k]);
    members     = 32'(hi - lo + 1);
    res.mean_q8 = MEAN_W'((total << FRAC_W) / members);
    res.count   = COUNT_W'(members);
    means_due.push_back(res);
  endtask

  function automatic logic [SAMPLE_W-1:0] clamp_mm(input int v);
    if (v < 0) return '0;
    if (v > 65535) return '1;
    return SAMPLE_W'(v);
  endfunction

  task automatic plan_sample(input int v, input int idle, input bit drain);
    plan_item_t it;
    it.sample_mm   = clamp_mm(v);
    it.idle_before = idle;
    it.drain_first = drain;
    sample_plan.push_back(it);
  endtask

  task automatic plan_directed();
    plan_sample(0, 0, 1'b0);                                  // all gaps zero
    repeat (4) plan_sample(65535, $urandom_range(0, 12), 1'b0); // zeros of reset vs max
    for (int k = 1; k <= 8; k++) plan_sample(100 * k, 0, 1'b0); // equal gaps, first wins
    repeat (5) plan_sample(1000, $urandom_range(0, 12), 1'b0);  // lower cluster, then upper
    repeat (3) plan_sample(9000, 0, 1'b0);
    plan_sample(16'h5555, 0, 1'b0);
    plan_sample(16'hAAAA, 0, 1'b0);
  endtask

  // Runs of plausible readings with noise and outliers, two-target and frozen runs, plus raw noise.
  task automatic plan_random(input int n_items);
    plan_mode_e mode;
    int         made;
    int         run_len;
    int         base;
    int         alt;
    int         v;
    int         max_idle;
    bit         drain;
    bit         first_run;
    made      = 0;
    first_run = 1'b1;
    while (made < n_items) begin
      mode     = plan_mode_e'($urandom_range(0, 3));
      run_len  = $urandom_range(8, 40);
      base     = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 65535)
                                              : $urandom_range(20, 6000);
      alt      = $urandom_range(0, 65535);
      max_idle = ($urandom_range(0, 3) == 0) ? 0 : 12;
      drain    = first_run || ($urandom_range(0, 5) == 0 &&
                 (sample_plan.size() < HOLD_AT - 40 || sample_plan.size() > HOLD_AT + 40));
      first_run = 1'b0;
      for (int k = 0; k < run_len && made < n_items; k++) begin
        case (mode)
          STEADY: begin
            v = base + $urandom_range(0, 30) - 15;
            if ($urandom_range(0, 7) == 0) v = $urandom_range(0, 65535);
          end
          UNIFORM:    v = $urandom_range(0, 65535);
          TWO_TARGET: v = ($urandom_range(0, 1) ? base : alt) + $urandom_range(0, 6) - 3;
          default:    v = base;
        endcase
        plan_sample(v, $urandom_range(0, max_idle), drain && k == 0);
        made++;
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin : sample_driver
    logic taken;
    int   idle_now;
    if (!rst_ni) begin
      in_valid_i  <= 1'b0;
      sample_mm_i <= '0;
      idle_cycles <= 0;
      items_sent  <= 0;
    end else begin
      taken    = in_valid_i && !in_stall_o;
      idle_now = idle_cycles;
      if (taken) begin
        shift_in_and_average(sample_mm_i);
        items_sent <= items_sent + 1;
        idle_now = 0;
      end
      if (!in_valid_i || taken) begin
        if (sample_plan.size() != 0 && idle_now >= sample_plan[0].idle_before &&
            (!sample_plan[0].drain_first || items_sent + int'(taken) == results_seen)) begin
          in_valid_i  <= 1'b1;
          sample_mm_i <= sample_plan[0].sample_mm;
          void'(sample_plan.pop_front());
          idle_cycles <= 0;
        end else begin
          in_valid_i  <= 1'b0;
          idle_cycles <= idle_now + 1;
        end
      end
    end
  end

  always @(posedge clk_i or negedge rst_ni) begin : result_monitor
    cluster_mean_t want;
    int            stall_now;
    int            hold_now;
    if (!rst_ni) begin
      out_stall_i  <= 1'b0;
      results_seen <= 0;
      stall_left   <= 0;
      hold_left    <= 0;
    end else begin
      stall_now = stall_left;
      hold_now  = hold_left;
      if (out_valid_o && !out_stall_i) begin
        if (means_due.size() == 0) begin
          $display("%0t: result with no item pending: mean %h count %0d", $time,
                   filtered_mm_q8_o, cluster_count_o);
          fails++;
        end else begin
          want = means_due.pop_front();
          if (filtered_mm_q8_o !== want.mean_q8) begin
            $display("%0t: filtered_mm_q8 expected %h actual %h", $time, want.mean_q8,
                     filtered_mm_q8_o);
            fails++;
          end
          if (cluster_count_o !== want.count) begin
            $display("%0t: cluster_count expected %0d actual %0d", $time, want.count,
                     cluster_count_o);
            fails++;
          end
        end
        results_seen <= results_seen + 1;
        // quiet stretch with the output always ready
        stall_now = (results_seen >= 800 && results_seen < 950) ? 0 : $urandom_range(0, 12);
        if (results_seen + 1 == HOLD_AT) hold_now = HOLD_CYCLES;
      end
      if (hold_now > 0) begin
        out_stall_i <= 1'b1;
        hold_left   <= hold_now - 1;
        stall_left  <= stall_now;
      end else if (stall_now > 0) begin
        out_stall_i <= 1'b1;
        stall_left  <= stall_now - 1;
      end else begin
        out_stall_i <= 1'b0;
        stall_left  <= 0;
      end
    end
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == LIMIT) begin
      $display("[window_gap_cluster_average_filter] ERROR");
      $finish;
    end
  end

  initial begin : run_control
    for (int k = 0; k < WINDOW; k++) window_mm[k] = '0;
    plan_directed();
    plan_random(RANDOM_N);
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    while (sample_plan.size() != 0 || in_valid_i || results_seen != items_sent)
      @(negedge clk_i);
    repeat (TAIL_CYCLES) @(negedge clk_i);
    if (means_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, means_due.size());
      fails++;
    end
    if (fails == 0) begin
      $display("[window_gap_cluster_average_filter] OK");
    end else begin
      $display("[window_gap_cluster_average_filter] ERROR");
    end
    $finish;
  end

endmodule

// ----- files.f -----
+incdir+hdl
hdl/wgca_pkg.sv
hdl/wgca_cell.sv
hdl/wgca_div.sv
hdl/window_gap_cluster_average_filter.sv
sim/window_gap_cluster_average_filter_test.sv
